// ===== hdl/aeu_pkg.sv =====
// ----------------------------------------------------------------------------
// aeu_pkg
// Types, constants and per-stage functions of the auto-exposure update pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package aeu_pkg;

  localparam int DIV1_STEPS = 11;
  localparam int DIV2_STEPS = 32;
  localparam int DIV3_STEPS = 9;
  localparam int ST_PREP    = 0;
  localparam int ST_RATIO   = DIV2_STEPS + 1;
  localparam int ST_MUL     = ST_RATIO + 1;
  localparam int ST_NEXT    = ST_MUL + 1;
  localparam int ST_SPLIT   = ST_NEXT + 1;
  localparam int ST_OUT     = ST_SPLIT + DIV3_STEPS + 1;
  localparam int N_STAGES   = ST_OUT + 1;

  localparam logic [15:0] DEADBAND       = 16'd65;
  localparam logic [28:0] CLIP_FACTOR    = 29'd20;
  localparam logic [11:0] RATIO_MAX      = 12'd2048;
  localparam logic [11:0] RATIO_MIN      = 12'd64;
  localparam logic [11:0] DAMP_LOW       = 12'd128;
  localparam logic [11:0] DAMP_HIGH      = 12'd512;
  localparam logic [11:0] CLIP_RATIO_CAP = 12'd192;
  localparam logic [8:0]  DIV_MIN        = 9'd24;
  localparam logic [8:0]  DIV_MAX        = 9'd256;
  localparam logic [31:0] RECIP_3        = 32'hAAAA_AAAB;

  localparam logic [15:0] RST_TARGET    = 16'd2048;
  localparam logic [15:0] RST_MAX_LINES = 16'd3500;
  localparam logic [15:0] RST_MIN_LINES = 16'd4;
  localparam logic [7:0]  RST_MAX_GAIN  = 8'd232;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_TARGET_MEAN   = 2'd0;
  localparam reg_idx_t REG_MAX_LINES     = 2'd1;
  localparam reg_idx_t REG_MIN_LINES     = 2'd2;
  localparam reg_idx_t REG_MAX_GAIN_CODE = 2'd3;

  typedef struct packed {
    logic [15:0] target_mean;
    logic [15:0] max_lines;
    logic [15:0] min_lines;
    logic [7:0]  max_gain_code;
  } cfg_t;

  typedef struct packed {
    logic        done;
    logic [15:0] res_lines;
    logic [7:0]  res_gain;
    logic        heavy;
    logic        rsat;
    logic [15:0] mean;
    logic [15:0] r1;
    logic [10:0] q1;
    logic [15:0] lines_in;
    logic [8:0]  dv;
    logic [7:0]  r2;
    logic [31:0] q2;
    logic [11:0] ratio;
    logic [27:0] cap;
    logic [43:0] prod;
    logic [27:0] nxt_v;
    logic [15:0] ln_out;
    logic [32:0] dnum;
    logic [27:0] r3;
    logic [8:0]  q3;
    logic        dsat;
    logic        dzero;
  } stage_t;

  function automatic stage_t aeu_prep(logic [15:0] lines_in, logic [7:0] gain_in,
                                      logic [15:0] mean, logic [23:0] clipped,
                                      logic [23:0] samples, cfg_t c);
    stage_t      s;
    logic [28:0] cl20;
    logic [15:0] lo;
    logic [16:0] hi;
    logic [15:0] m1;
    logic        inband;
    logic        dark;
    logic [7:0]  g;
    s = '0;
    cl20 = {5'b0, clipped} * CLIP_FACTOR;
    s.heavy = cl20 > {5'b0, samples};
    lo = (c.target_mean >= DEADBAND) ? c.target_mean - DEADBAND : 16'd0;
    hi = {1'b0, c.target_mean} + {1'b0, DEADBAND};
    inband = (mean >= lo) && ({1'b0, mean} <= hi);
    m1 = (mean == 16'd0) ? 16'd1 : mean;
    dark = {m1, 4'b0} < {4'b0, c.target_mean};
    g = (gain_in > c.max_gain_code) ? c.max_gain_code : gain_in;
    s.dv = DIV_MAX - {1'b0, g};
    s.rsat = {3'b0, c.target_mean} >= {m1, 3'b0};
    s.mean = m1;
    s.lines_in = lines_in;
    s.r1 = {3'b0, c.target_mean[15:3]};
    s.res_lines = lines_in;
    s.res_gain = gain_in;
    if (samples == 24'd0) begin
      s.done = 1'b1;
    end else if (inband && !s.heavy) begin
      s.done = 1'b1;
    end else if (dark) begin
      s.done = 1'b1;
      s.res_lines = c.max_lines;
      s.res_gain = c.max_gain_code;
    end
    return s;
  endfunction

  function automatic stage_t aeu_step(int idx, stage_t si, cfg_t c);
    stage_t      s;
    logic [23:0] n1;
    logic [31:0] n2;
    logic [16:0] t1;
    logic [8:0]  t2;
    logic [28:0] t3;
    logic [11:0] r;
    logic [28:0] x;
    logic [60:0] m;
    logic [44:0] p;
    logic [36:0] n;
    logic [28:0] l;
    logic [20:0] ln;
    logic [8:0]  dv;
    s = si;
    n1 = {c.target_mean, 8'b0};
    n2 = {si.lines_in, 16'b0};
    if (idx >= 1 && idx <= DIV1_STEPS) begin
      t1 = {si.r1, n1[DIV1_STEPS - idx]};
      if (t1 >= {1'b0, si.mean}) begin
        t1 = t1 - {1'b0, si.mean};
        s.q1 = {si.q1[9:0], 1'b1};
      end else begin
        s.q1 = {si.q1[9:0], 1'b0};
      end
      s.r1 = t1[15:0];
    end
    if (idx >= 1 && idx <= DIV2_STEPS) begin
      t2 = {si.r2, n2[DIV2_STEPS - idx]};
      if (t2 >= si.dv) begin
        t2 = t2 - si.dv;
        s.q2 = {si.q2[30:0], 1'b1};
      end else begin
        s.q2 = {si.q2[30:0], 1'b0};
      end
      s.r2 = t2[7:0];
    end
    if (idx == ST_RATIO) begin
      r = si.rsat ? RATIO_MAX : {1'b0, si.q1};
      if (r < RATIO_MIN) r = RATIO_MIN;
      if (r > DAMP_LOW && r < DAMP_HIGH) r = 12'(({1'b0, r} + 13'd256) >> 1);
      if (si.heavy && r > CLIP_RATIO_CAP) r = CLIP_RATIO_CAP;
      s.ratio = r;
      x = {c.max_lines, 13'b0};
      m = 61'(x) * 61'(RECIP_3);
      s.cap = m[60:33];
    end
    if (idx == ST_MUL) begin
      s.prod = 44'(si.q2) * 44'(si.ratio);
    end
    if (idx == ST_NEXT) begin
      p = {1'b0, si.prod} + 45'd128;
      n = p[44:8];
      if (n < 37'({c.min_lines, 8'b0})) n = 37'({c.min_lines, 8'b0});
      if (n > 37'(si.cap)) n = 37'(si.cap);
      s.nxt_v = n[27:0];
    end
    if (idx == ST_SPLIT) begin
      l = {1'b0, si.nxt_v} + 29'd128;
      ln = l[28:8];
      if (ln > 21'(c.max_lines)) ln = 21'(c.max_lines);
      s.ln_out = ln[15:0];
      s.dnum = {1'b0, ln[15:0], 16'b0} + 33'(si.nxt_v >> 1);
      s.dsat = {4'b0, s.dnum} >= {si.nxt_v, 9'b0};
      s.dzero = si.nxt_v == 28'd0;
      s.r3 = {4'b0, s.dnum[32:9]};
      s.q3 = 9'd0;
    end
    if (idx > ST_SPLIT && idx < ST_OUT) begin
      t3 = {si.r3, si.dnum[ST_OUT - 1 - idx]};
      if (t3 >= {1'b0, si.nxt_v}) begin
        t3 = t3 - {1'b0, si.nxt_v};
        s.q3 = {si.q3[7:0], 1'b1};
      end else begin
        s.q3 = {si.q3[7:0], 1'b0};
      end
      s.r3 = t3[27:0];
    end
    if (idx == ST_OUT) begin
      dv = (si.dzero || si.dsat) ? DIV_MAX : si.q3;
      if (dv > DIV_MAX) dv = DIV_MAX;
      if (dv < DIV_MIN) dv = DIV_MIN;
      if (!si.done) begin
        s.res_lines = si.ln_out;
        s.res_gain = 8'(DIV_MAX - dv);
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/auto_exposure_update.sv =====
// ----------------------------------------------------------------------------
// auto_exposure_update
// Per-frame exposure step: frame statistics in, next lines and gain out.
// ----------------------------------------------------------------------------
// channel  direction  handshake            word
// in       input      in_valid/in_ready    current setting and frame stats
// out      output     out_valid/out_ready  next lines and gain code
// cfg      input      cfg_valid/cfg_ready  register index and data
//
// The result word passes through every pipe stage after the input word is accepted;
// one word enters every cycle unless the output stalls.
// Depth is set chiefly by the 32-step budget divider, one quotient bit per stage.
// Reset clears all stage valid bits and loads the register defaults.
// A stall at the output freezes the whole pipe; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module auto_exposure_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_current_lines,
  input  logic [7:0]         in_current_gain,
  input  logic [15:0]        in_frame_mean,
  input  logic [23:0]        in_clipped_count,
  input  logic [23:0]        in_sample_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_next_lines,
  output logic [7:0]         out_next_gain,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  aeu_pkg::reg_idx_t  cfg_index,
  input  logic [15:0]        cfg_data
);
  import aeu_pkg::*;

  cfg_t   cfg_r;
  logic   v_r   [N_STAGES];
  stage_t s_r   [N_STAGES];
  stage_t s_nxt [N_STAGES];
  logic   adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_mean   <= RST_TARGET;
      cfg_r.max_lines     <= RST_MAX_LINES;
      cfg_r.min_lines     <= RST_MIN_LINES;
      cfg_r.max_gain_code <= RST_MAX_GAIN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET_MEAN:   cfg_r.target_mean   <= cfg_data;
        REG_MAX_LINES:     cfg_r.max_lines     <= cfg_data;
        REG_MIN_LINES:     cfg_r.min_lines     <= cfg_data;
        REG_MAX_GAIN_CODE: cfg_r.max_gain_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign adv      = !v_r[ST_OUT] || out_ready;
  assign in_ready = adv;

  assign s_nxt[ST_PREP] = aeu_prep(in_current_lines, in_current_gain, in_frame_mean,
                                   in_clipped_count, in_sample_count, cfg_r);

  for (genvar gi = 1; gi < N_STAGES; gi++) begin : g_stage
    assign s_nxt[gi] = aeu_step(gi, s_r[gi-1], cfg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_STAGES; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < N_STAGES; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < N_STAGES; i++) s_r[i] <= s_nxt[i];
    end
  end

  assign out_valid      = v_r[ST_OUT];
  assign out_next_lines = s_r[ST_OUT].res_lines;
  assign out_next_gain  = s_r[ST_OUT].res_gain;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !s_r[ST_OUT].done |-> out_next_gain <= 8'd232)
    else $error("computed gain code out of range");

  a_lines_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !s_r[ST_OUT].done |-> out_next_lines <= cfg_r.max_lines)
    else $error("computed lines above limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r[ST_OUT - 1]) && $stable(s_r[ST_OUT - 1]))
    else $error("pipe moved during stall");

endmodule

`default_nettype wire

// ===== sim/auto_exposure_update_test.sv =====
// ----------------------------------------------------------------------------
// auto_exposure_update_test
// Self-checking bench for the auto-exposure update step. A directed table
// covers pass-through, deadband, dark-frame and clipping cases, then register extremes;
// random frames follow under three idling mixes over six phases and several register sets.
// Every result word is checked against a built-in exposure predictor or a given expected setting.
// ----------------------------------------------------------------------------
`default_nettype none

module auto_exposure_update_test;
  import aeu_pkg::*;

  localparam int LATENCY  = 47;
  localparam int WDOG_MAX = 20000;

  typedef struct {
    logic [15:0] lines;
    logic [7:0]  gain;
    logic [15:0] mean;
    logic [23:0] clipped;
    logic [23:0] samples;
    bit          typed;
    logic [15:0] x_lines;
    logic [7:0]  x_gain;
  } frame_t;

  typedef struct {
    logic [15:0] lines;
    logic [7:0]  gain;
  } setting_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_current_lines;
  logic [7:0]  in_current_gain;
  logic [15:0] in_frame_mean;
  logic [23:0] in_clipped_count;
  logic [23:0] in_sample_count;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_next_lines;
  logic [7:0]  out_next_gain;
  logic        cfg_valid;
  logic        cfg_ready;
  reg_idx_t    cfg_index;
  logic [15:0] cfg_data;

  logic [15:0] tgt_mean, lines_max, lines_min;
  logic [7:0]  gain_max;
  setting_t    pending_q[$];
  int          mismatches;
  int          watchdog;
  int          send_idle, recv_idle;
  bit          timed_out;

  auto_exposure_update u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_current_lines(in_current_lines), .in_current_gain(in_current_gain),
    .in_frame_mean(in_frame_mean), .in_clipped_count(in_clipped_count),
    .in_sample_count(in_sample_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_next_lines(out_next_lines), .out_next_gain(out_next_gain),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic setting_t next_exposure(frame_t f);
    setting_t   r;
    bit         heavy;
    longint unsigned lo, hi, m, ratio, g, budget, nxt, ln, dv, cap;
    r.lines = f.lines;
    r.gain  = f.gain;
    if (f.samples == 0) return r;
    heavy = 64'(f.clipped) * 20 > 64'(f.samples);
    lo = (tgt_mean >= 65) ? tgt_mean - 65 : 0;
    hi = 64'(tgt_mean) + 65;
    if (f.mean >= lo && f.mean <= hi && !heavy) return r;
    m = (f.mean == 0) ? 1 : f.mean;
    if (m * 16 < tgt_mean) begin
      r.lines = lines_max;
      r.gain  = gain_max;
      return r;
    end
    ratio = 64'(tgt_mean) * 256 / m;
    if (ratio > 2048) ratio = 2048;
    if (ratio < 64) ratio = 64;
    if (ratio > 128 && ratio < 512) ratio = (ratio + 256) / 2;
    if (heavy && ratio > 192) ratio = 192;
    g = (f.gain > gain_max) ? gain_max : f.gain;
    budget = 64'(f.lines) * 65536 / (256 - g);
    nxt = (budget * ratio + 128) / 256;
    if (nxt < 64'(lines_min) * 256) nxt = 64'(lines_min) * 256;
    cap = 64'(lines_max) * 65536 / 24;
    if (nxt > cap) nxt = cap;
    ln = (nxt + 128) / 256;
    if (ln > lines_max) ln = lines_max;
    dv = (nxt == 0) ? 256 : (ln * 65536 + nxt / 2) / nxt;
    if (dv > 256) dv = 256;
    if (dv < 24) dv = 24;
    r.lines = ln[15:0];
    r.gain  = 8'(256 - dv);
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TARGET_MEAN:   tgt_mean  = val;
      REG_MAX_LINES:     lines_max = val;
      REG_MIN_LINES:     lines_min = val;
      REG_MAX_GAIN_CODE: gain_max  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_frame(frame_t f);
    setting_t e;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_current_lines <= f.lines;
    in_current_gain  <= f.gain;
    in_frame_mean    <= f.mean;
    in_clipped_count <= f.clipped;
    in_sample_count  <= f.samples;
    do @(posedge clk); while (!in_ready);
    e = next_exposure(f);
    if (f.typed) begin
      e.lines = f.x_lines;
      e.gain  = f.x_gain;
    end
    pending_q.push_back(e);
  endtask

  function automatic frame_t mk(logic [15:0] l, logic [7:0] g, logic [15:0] m,
                                logic [23:0] c, logic [23:0] s);
    frame_t f;
    f.lines = l; f.gain = g; f.mean = m; f.clipped = c; f.samples = s;
    f.typed = 1'b0; f.x_lines = '0; f.x_gain = '0;
    return f;
  endfunction

  function automatic frame_t mkx(logic [15:0] l, logic [7:0] g, logic [15:0] m,
                                 logic [23:0] c, logic [23:0] s,
                                 logic [15:0] xl, logic [7:0] xg);
    frame_t f;
    f = mk(l, g, m, c, s);
    f.typed = 1'b1; f.x_lines = xl; f.x_gain = xg;
    return f;
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int     k;
    k = $urandom_range(9);
    f = mk(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
           16'($urandom_range(0, 65535)), 24'($urandom_range(0, 16777215)),
           24'($urandom_range(0, 16777215)));
    if (k < 6) begin
      f.lines   = 16'($urandom_range(1, 4000));
      f.mean    = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(tgt_mean / 20 + 1,
                                                                tgt_mean * 4 + 200));
      f.samples = 24'($urandom_range(1, 16777215));
      f.clipped = ($urandom_range(1) == 0) ? 24'(f.samples / $urandom_range(21, 4000))
                                           : 24'(f.samples / $urandom_range(1, 20));
    end else if (k == 6) begin
      f.samples = '0;
    end else if (k == 7) begin
      f.mean    = 16'(tgt_mean + $urandom_range(0, 130) - 65);
      f.samples = 24'($urandom_range(20, 16777215));
      f.clipped = f.samples / 24'd40;
    end
    return f;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      watchdog  <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        watchdog <= 0;
      else
        watchdog <= watchdog + 1;
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: lines %0d gain %0d",
                                         out_next_lines, out_next_gain);
        end else begin
          if (out_next_lines !== pending_q[0].lines || out_next_gain !== pending_q[0].gain) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp lines %0d gain %0d, got lines %0d gain %0d",
                       pending_q[0].lines, pending_q[0].gain, out_next_lines, out_next_gain);
          end
          void'(pending_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (watchdog >= WDOG_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("[auto_exposure_update] ERROR");
      $finish;
    end
  end

  initial begin
    frame_t directed[$];
    int     phase;
    mismatches = 0;
    timed_out  = 1'b0;
    send_idle  = 0;
    recv_idle  = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_current_lines = '0; in_current_gain = '0; in_frame_mean = '0;
    in_clipped_count = '0; in_sample_count = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_TARGET_MEAN;
    cfg_data   = '0;
    tgt_mean = RST_TARGET; lines_max = RST_MAX_LINES;
    lines_min = RST_MIN_LINES; gain_max = RST_MAX_GAIN;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      mkx(16'd1000, 8'd10, 16'd2048, 24'd0, 24'd0, 16'd1000, 8'd10),
      mkx(16'hFFFF, 8'hFF, 16'hFFFF, 24'hFFFFFF, 24'd0, 16'hFFFF, 8'hFF),
      mkx(16'd500, 8'd40, 16'd1983, 24'd0, 24'd1000, 16'd500, 8'd40),
      mkx(16'd500, 8'd40, 16'd2113, 24'd50, 24'd1000, 16'd500, 8'd40),
      mkx(16'd500, 8'd40, 16'd0, 24'd0, 24'd1000, 16'd3500, 8'd232),
      mkx(16'd500, 8'd40, 16'd127, 24'd0, 24'd1000, 16'd3500, 8'd232),
      mk(16'd500, 8'd40, 16'd128, 24'd0, 24'd1000),
      mk(16'd500, 8'd40, 16'd2048, 24'd51, 24'd1000),
      mk(16'd500, 8'd40, 16'd1000, 24'd900, 24'd1000),
      mk(16'd500, 8'hFF, 16'd3000, 24'd0, 24'd1000),
      mk(16'd0, 8'd0, 16'd4000, 24'd0, 24'd1000),
      mk(16'hFFFF, 8'd232, 16'd300, 24'd0, 24'hFFFFFF),
      mk(16'd1, 8'd0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF),
      mk(16'd3000, 8'd100, 16'd1500, 24'd0, 24'd1),
      mk(16'd200, 8'd200, 16'd2500, 24'd10, 24'd100)
    };
    foreach (directed[i]) send_frame(directed[i]);
    drain();

    write_reg(REG_TARGET_MEAN, 16'd66);
    write_reg(REG_MAX_LINES, 16'd1);
    write_reg(REG_MIN_LINES, 16'd1);
    write_reg(REG_MAX_GAIN_CODE, 16'd0);
    send_frame(mk(16'd10, 8'd5, 16'd0, 24'd0, 24'd5));
    send_frame(mk(16'd10, 8'd5, 16'd300, 24'd0, 24'd5));
    send_frame(mk(16'hFFFF, 8'hFF, 16'd5, 24'd1, 24'd5));
    drain();
    write_reg(REG_TARGET_MEAN, 16'hFFFF);
    write_reg(REG_MAX_LINES, 16'hFFFF);
    write_reg(REG_MIN_LINES, 16'hFFFF);
    write_reg(REG_MAX_GAIN_CODE, 16'd232);
    send_frame(mk(16'hFFFF, 8'hFF, 16'hFFFF, 24'd0, 24'd100));
    send_frame(mk(16'd1, 8'd0, 16'd5000, 24'd0, 24'd100));
    drain();

    for (phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle = 27; recv_idle = 61; end
        1: begin send_idle = 61; recv_idle = 27; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (phase)
        0: begin write_reg(REG_TARGET_MEAN, 16'd2048); write_reg(REG_MAX_LINES, 16'd3500);
                 write_reg(REG_MIN_LINES, 16'd4); write_reg(REG_MAX_GAIN_CODE, 16'd232); end
        1: begin write_reg(REG_TARGET_MEAN, 16'($urandom_range(66, 65535)));
                 write_reg(REG_MAX_LINES, 16'($urandom_range(1, 65535)));
                 write_reg(REG_MIN_LINES, 16'($urandom_range(1, 200)));
                 write_reg(REG_MAX_GAIN_CODE, 16'($urandom_range(0, 232))); end
        2: begin write_reg(REG_TARGET_MEAN, 16'd66); write_reg(REG_MAX_LINES, 16'hFFFF);
                 write_reg(REG_MIN_LINES, 16'd1); write_reg(REG_MAX_GAIN_CODE, 16'd0); end
        3: begin write_reg(REG_TARGET_MEAN, 16'd30000); write_reg(REG_MAX_LINES, 16'd5000);
                 write_reg(REG_MIN_LINES, 16'd10); write_reg(REG_MAX_GAIN_CODE, 16'd128); end
        4: begin write_reg(REG_TARGET_MEAN, 16'hFFFF); write_reg(REG_MAX_LINES, 16'd800);
                 write_reg(REG_MIN_LINES, 16'd2000); write_reg(REG_MAX_GAIN_CODE, 16'd200); end
        default: begin write_reg(REG_TARGET_MEAN, 16'd4096); write_reg(REG_MAX_LINES, 16'd2000);
                 write_reg(REG_MIN_LINES, 16'd2); write_reg(REG_MAX_GAIN_CODE, 16'd232); end
      endcase
      repeat (150) send_frame(rand_frame());
      drain();
    end

    if (mismatches == 0)
      $display("[auto_exposure_update] OK");
    else
      $display("[auto_exposure_update] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
